// ===== rtl/mtgd_pkg.sv =====
// Shared types, constants and a helper function for the multi-tap gesture detector.
`default_nettype none
package mtgd_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned THR_BITS   = 13;
  localparam int unsigned TOL_BITS   = 6;
  localparam int unsigned CFG_BITS   = THR_BITS;

  localparam logic [TOL_BITS-1:0]   TOL_MOUSE  = TOL_BITS'(1);
  localparam logic [TOL_BITS-1:0]   TOL_TOUCH  = TOL_BITS'(40);
  localparam logic [THR_BITS-1:0]   THR_RESET  = THR_BITS'(500);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    CMD_BEGAN     = 2'd0,
    CMD_MOVED     = 2'd1,
    CMD_ENDED     = 2'd2,
    CMD_CANCELLED = 2'd3
  } cmd_e;

  typedef enum logic {
    CFG_THRESHOLD = 1'b0,
    CFG_TOUCH     = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]                   command;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic [TIME_BITS-1:0]         time_ms;
  } in_t;

  typedef struct packed {
    logic                         tap_occurred;
    logic signed [COORD_BITS-1:0] tap_x;
    logic signed [COORD_BITS-1:0] tap_y;
    logic [15:0]                  tap_count;
  } out_t;

  typedef struct packed {
    logic [THR_BITS-1:0] threshold_ms;
    logic                touchscreen;
  } cfg_t;

  // Two points are near when both coordinate distances are within the tolerance.
  function automatic logic near(input logic signed [COORD_BITS-1:0] ax,
                                input logic signed [COORD_BITS-1:0] ay,
                                input logic signed [COORD_BITS-1:0] bx,
                                input logic signed [COORD_BITS-1:0] by,
                                input logic [TOL_BITS-1:0] tol);
    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic [COORD_BITS:0]        adx;
    logic [COORD_BITS:0]        ady;
    dx  = {ax[COORD_BITS-1], ax} - {bx[COORD_BITS-1], bx};
    dy  = {ay[COORD_BITS-1], ay} - {by[COORD_BITS-1], by};
    adx = dx[COORD_BITS] ? (COORD_BITS+1)'(0) - dx : dx;
    ady = dy[COORD_BITS] ? (COORD_BITS+1)'(0) - dy : dy;
    near = (adx <= (COORD_BITS+1)'(tol)) && (ady <= (COORD_BITS+1)'(tol));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mtgd_tracker.sv =====
// Press and tap tracking state with the per-event tap decision logic.
`default_nettype none
module mtgd_tracker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          ev_valid_i,
  input  wire mtgd_pkg::in_t ev_i,
  input  wire mtgd_pkg::cfg_t cfg_i,
  output mtgd_pkg::out_t     res_o
);

  logic                                   first_valid_q, first_valid_d;
  logic signed [mtgd_pkg::COORD_BITS-1:0] first_x_q, first_x_d;
  logic signed [mtgd_pkg::COORD_BITS-1:0] first_y_q, first_y_d;
  logic                                   last_valid_q, last_valid_d;
  logic signed [mtgd_pkg::COORD_BITS-1:0] last_x_q, last_x_d;
  logic signed [mtgd_pkg::COORD_BITS-1:0] last_y_q, last_y_d;
  logic                                   tap_valid_q, tap_valid_d;
  logic [mtgd_pkg::TIME_BITS-1:0]         tap_time_q, tap_time_d;
  logic [mtgd_pkg::COUNT_BITS-1:0]        count_q, count_d;

  logic [mtgd_pkg::TOL_BITS-1:0]  tol;
  logic [mtgd_pkg::TIME_BITS-1:0] gap;
  logic                           near_first;
  logic                           near_last;
  logic                           tap;

  assign tol = cfg_i.touchscreen ? mtgd_pkg::TOL_TOUCH : mtgd_pkg::TOL_MOUSE;
  assign gap = ev_i.time_ms - tap_time_q;
  assign near_first = mtgd_pkg::near(ev_i.pos_x, ev_i.pos_y, first_x_q, first_y_q, tol);
  assign near_last  = mtgd_pkg::near(ev_i.pos_x, ev_i.pos_y, last_x_q, last_y_q, tol);

  always_comb begin
    first_valid_d = first_valid_q;
    first_x_d     = first_x_q;
    first_y_d     = first_y_q;
    last_valid_d  = last_valid_q;
    last_x_d      = last_x_q;
    last_y_d      = last_y_q;
    tap_valid_d   = tap_valid_q;
    tap_time_d    = tap_time_q;
    count_d       = count_q;
    tap           = 1'b0;
    unique case (mtgd_pkg::cmd_e'(ev_i.command))
      mtgd_pkg::CMD_BEGAN: begin
        first_valid_d = 1'b1;
        last_valid_d  = 1'b1;
        last_x_d      = ev_i.pos_x;
        last_y_d      = ev_i.pos_y;
        if (!first_valid_q || !near_first) begin
          first_x_d = ev_i.pos_x;
          first_y_d = ev_i.pos_y;
        end
        if (first_valid_q && !near_first) begin
          count_d     = '0;
          tap_valid_d = 1'b0;
        end
      end
      mtgd_pkg::CMD_ENDED: begin
        if (last_valid_q && near_last) begin
          tap = 1'b1;
          if (!tap_valid_q ||
              gap > mtgd_pkg::TIME_BITS'(cfg_i.threshold_ms)) begin
            count_d = mtgd_pkg::COUNT_BITS'(1);
          end else if (count_q != mtgd_pkg::COUNT_MAX) begin
            count_d = count_q + mtgd_pkg::COUNT_BITS'(1);
          end
          tap_valid_d  = 1'b1;
          tap_time_d   = ev_i.time_ms;
          last_valid_d = 1'b0;
        end
      end
      mtgd_pkg::CMD_MOVED: begin
        if (last_valid_q && !near_last) begin
          first_valid_d = 1'b0;
          last_valid_d  = 1'b0;
          tap_valid_d   = 1'b0;
          count_d       = '0;
        end
      end
      mtgd_pkg::CMD_CANCELLED: begin
        first_valid_d = 1'b0;
        last_valid_d  = 1'b0;
        tap_valid_d   = 1'b0;
        count_d       = '0;
      end
      default: begin
        first_valid_d = 1'b0;
        last_valid_d  = 1'b0;
        tap_valid_d   = 1'b0;
        count_d       = '0;
      end
    endcase
  end

  always_comb begin
    res_o = '0;
    if (tap) begin
      res_o.tap_occurred = 1'b1;
      res_o.tap_x        = ev_i.pos_x;
      res_o.tap_y        = ev_i.pos_y;
      res_o.tap_count    = 16'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_valid_q <= 1'b0;
      last_valid_q  <= 1'b0;
      tap_valid_q   <= 1'b0;
      count_q       <= '0;
    end else if (ev_valid_i) begin
      first_valid_q <= first_valid_d;
      last_valid_q  <= last_valid_d;
      tap_valid_q   <= tap_valid_d;
      count_q       <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_valid_i) begin
      first_x_q  <= first_x_d;
      first_y_q  <= first_y_d;
      last_x_q   <= last_x_d;
      last_y_q   <= last_y_d;
      tap_time_q <= tap_time_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/multi_tap_gesture_detector.sv =====
// Top level of the multi-tap gesture detector: configuration, handshakes and result register.
// The block takes one pointer event per clock cycle and returns exactly one result
// transaction for each in the cycle after the event is accepted. The tracking state is
// updated in the same cycle the event is taken, so successive events may arrive on
// consecutive cycles. A single output register holds the result; while it is full and
// the downstream side stalls, in_stall_o is raised, otherwise a new event is taken even
// in the cycle in which the previous result leaves. Configuration writes take effect on
// the next event and should only be made while no event is in flight.
`default_nettype none
module multi_tap_gesture_detector (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_idx_i,
  input  wire logic [mtgd_pkg::CFG_BITS-1:0]  cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire mtgd_pkg::in_t                  in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output mtgd_pkg::out_t                      out_data_o
);

  mtgd_pkg::cfg_t cfg_q;
  mtgd_pkg::out_t res;
  mtgd_pkg::out_t out_data_q;
  logic           out_valid_q;
  logic           in_accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold_ms <= mtgd_pkg::THR_RESET;
      cfg_q.touchscreen  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (mtgd_pkg::cfg_idx_e'(cfg_idx_i))
        mtgd_pkg::CFG_THRESHOLD: cfg_q.threshold_ms <= cfg_data_i;
        mtgd_pkg::CFG_TOUCH:     cfg_q.touchscreen  <= cfg_data_i[0];
        default:                 cfg_q              <= cfg_q;
      endcase
    end
  end

  mtgd_tracker u_tracker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ev_valid_i (in_accept),
    .ev_i       (in_data_i),
    .cfg_i      (cfg_q),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted event produced no result");

  a_no_tap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.tap_occurred |->
      out_data_o.tap_x == '0 && out_data_o.tap_y == '0 && out_data_o.tap_count == '0)
    else $error("non-tap result carries data");

  a_tap_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.tap_occurred |-> out_data_o.tap_count != '0)
    else $error("tap reported with zero count");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the multi-tap gesture detector, with its own tap predictor.
module testbench;

  localparam int CYCLE_LIMIT  = 40000;
  localparam int PHASE_EVENTS = 320;
  localparam int RUN_TAPS     = 40;

  logic                          clk_i      = 1'b0;
  logic                          rst_ni     = 1'b0;
  logic                          cfg_we_i   = 1'b0;
  logic                          cfg_idx_i  = 1'b0;
  logic [mtgd_pkg::CFG_BITS-1:0] cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  mtgd_pkg::in_t                 in_data_i  = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  mtgd_pkg::out_t                out_data_o;

  logic [mtgd_pkg::THR_BITS-1:0]          thr_ms     = mtgd_pkg::THR_RESET;
  logic                                   touch_mode = 1'b0;
  logic                                   first_ok, last_ok, tap_ok;
  logic signed [mtgd_pkg::COORD_BITS-1:0] first_x, first_y, last_x, last_y;
  logic [mtgd_pkg::TIME_BITS-1:0]         tap_time;
  logic [mtgd_pkg::COUNT_BITS-1:0]        tap_run;

  mtgd_pkg::out_t taps_due[$];
  int   mismatches  = 0;
  int   cycles      = 0;
  int   events_sent = 0;
  bit   steady      = 1'b0;

  multi_tap_gesture_detector uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) out_stall_i <= !steady && ($urandom_range(99) < 9);

  function automatic void forget_gesture();
    first_ok = 1'b0;
    first_x  = '0;
    first_y  = '0;
    last_ok  = 1'b0;
    last_x   = '0;
    last_y   = '0;
    tap_ok   = 1'b0;
    tap_time = '0;
    tap_run  = '0;
  endfunction

  function automatic bit close_to(input logic signed [mtgd_pkg::COORD_BITS-1:0] ax, ay, bx, by);
    int reach, dx, dy;
    reach = touch_mode ? int'(mtgd_pkg::TOL_TOUCH) : int'(mtgd_pkg::TOL_MOUSE);
    dx = int'(ax) - int'(bx);
    dy = int'(ay) - int'(by);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return dx <= reach && dy <= reach;
  endfunction

  function automatic mtgd_pkg::out_t predict_tap(input mtgd_pkg::in_t ev);
    mtgd_pkg::out_t                 res;
    logic [mtgd_pkg::TIME_BITS-1:0] gap;
    res = '0;
    case (mtgd_pkg::cmd_e'(ev.command))
      mtgd_pkg::CMD_BEGAN: begin
        if (!first_ok) begin
          first_ok = 1'b1;
          first_x  = ev.pos_x;
          first_y  = ev.pos_y;
        end
        last_ok = 1'b1;
        last_x  = ev.pos_x;
        last_y  = ev.pos_y;
        if (!close_to(last_x, last_y, first_x, first_y)) begin
          tap_run  = '0;
          tap_ok   = 1'b0;
          tap_time = '0;
          first_x  = last_x;
          first_y  = last_y;
        end
      end
      mtgd_pkg::CMD_ENDED: begin
        if (last_ok && close_to(ev.pos_x, ev.pos_y, last_x, last_y)) begin
          gap = ev.time_ms - tap_time;
          if (!tap_ok || gap > mtgd_pkg::TIME_BITS'(thr_ms)) begin
            tap_run = mtgd_pkg::COUNT_BITS'(1);
          end else if (tap_run != mtgd_pkg::COUNT_MAX) begin
            tap_run++;
          end
          tap_ok   = 1'b1;
          tap_time = ev.time_ms;
          last_ok  = 1'b0;
          last_x   = '0;
          last_y   = '0;
          res.tap_occurred = 1'b1;
          res.tap_x        = ev.pos_x;
          res.tap_y        = ev.pos_y;
          res.tap_count    = tap_run;
        end
      end
      mtgd_pkg::CMD_MOVED: begin
        if (last_ok && !close_to(ev.pos_x, ev.pos_y, last_x, last_y)) forget_gesture();
      end
      default: begin
        forget_gesture();
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i) begin : check_taps
    mtgd_pkg::out_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (taps_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction: occurred=%0b x=%0d y=%0d count=%0d",
                   out_data_o.tap_occurred, out_data_o.tap_x, out_data_o.tap_y,
                   out_data_o.tap_count);
      end else begin
        due = taps_due.pop_front();
        if (out_data_o.tap_occurred !== due.tap_occurred || out_data_o.tap_x !== due.tap_x ||
            out_data_o.tap_y !== due.tap_y || out_data_o.tap_count !== due.tap_count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("tap mismatch: expected occurred=%0b x=%0d y=%0d count=%0d",
                     due.tap_occurred, due.tap_x, due.tap_y, due.tap_count);
            $display("              got occurred=%0b x=%0d y=%0d count=%0d",
                     out_data_o.tap_occurred, out_data_o.tap_x, out_data_o.tap_y,
                     out_data_o.tap_count);
          end
        end
      end
    end
  end

  task automatic send_event(input mtgd_pkg::cmd_e cmd,
                            input logic signed [mtgd_pkg::COORD_BITS-1:0] x,
                            input logic signed [mtgd_pkg::COORD_BITS-1:0] y,
                            input logic [mtgd_pkg::TIME_BITS-1:0] stamp);
    mtgd_pkg::in_t ev;
    ev.command = cmd;
    ev.pos_x   = x;
    ev.pos_y   = y;
    ev.time_ms = stamp;
    if (!steady && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= ev;
    do @(posedge clk_i); while (in_stall_o);
    taps_due.push_back(predict_tap(ev));
    events_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (taps_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_register(input mtgd_pkg::cfg_idx_e idx,
                                input logic [mtgd_pkg::CFG_BITS-1:0] value);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == mtgd_pkg::CFG_THRESHOLD) thr_ms = value;
    else touch_mode = value[0];
  endtask

  task automatic set_touchscreen(input bit on);
    logic [mtgd_pkg::CFG_BITS-1:0] word;
    word    = mtgd_pkg::CFG_BITS'($urandom);
    word[0] = on;
    write_register(mtgd_pkg::CFG_TOUCH, word);
  endtask

  function automatic int jitter(input int reach);
    int r;
    r = $urandom_range(99);
    if (r < 75) return int'($urandom_range(2 * reach)) - reach;
    if (r < 85) return reach + 1;
    if (r < 95) return -(reach + 1);
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic logic signed [mtgd_pkg::COORD_BITS-1:0] shifted(
      input logic signed [mtgd_pkg::COORD_BITS-1:0] base, input int reach);
    return mtgd_pkg::COORD_BITS'(int'(base) + jitter(reach));
  endfunction

  function automatic logic [mtgd_pkg::TIME_BITS-1:0] tap_gap();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $urandom_range(int'(thr_ms));
    if (r < 65) return mtgd_pkg::TIME_BITS'(thr_ms);
    if (r < 80) return mtgd_pkg::TIME_BITS'(thr_ms) + mtgd_pkg::TIME_BITS'(1);
    if (r < 93) return $urandom_range(3 * int'(thr_ms) + 2, int'(thr_ms) + 1);
    return $urandom;
  endfunction

  task automatic random_gestures(input int quota, input bit pause_midway);
    logic signed [mtgd_pkg::COORD_BITS-1:0] bx, by, px, py;
    logic [mtgd_pkg::TIME_BITS-1:0]         anchor, stamp;
    int                                     reach, target;
    bit                                     paused;
    bx     = mtgd_pkg::COORD_BITS'($urandom);
    by     = mtgd_pkg::COORD_BITS'($urandom);
    anchor = $urandom;
    target = events_sent + quota;
    paused = 1'b0;
    while (events_sent < target) begin
      reach = touch_mode ? int'(mtgd_pkg::TOL_TOUCH) : int'(mtgd_pkg::TOL_MOUSE);
      if (pause_midway && !paused && events_sent >= target - quota / 2) begin
        settle();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 6) begin
        bx = mtgd_pkg::COORD_BITS'($urandom);
        by = mtgd_pkg::COORD_BITS'($urandom);
      end
      if ($urandom_range(99) < 80) begin
        anchor = anchor + tap_gap();
        stamp  = anchor - $urandom_range(60);
        px     = shifted(bx, reach);
        py     = shifted(by, reach);
        if ($urandom_range(99) < 95) send_event(mtgd_pkg::CMD_BEGAN, px, py, stamp);
        repeat ($urandom_range(2)) begin
          stamp = stamp + $urandom_range(20);
          send_event(mtgd_pkg::CMD_MOVED, shifted(px, reach), shifted(py, reach), stamp);
        end
        send_event(mtgd_pkg::CMD_ENDED, shifted(px, reach), shifted(py, reach), anchor);
      end else begin
        send_event(mtgd_pkg::cmd_e'($urandom_range(3)), mtgd_pkg::COORD_BITS'($urandom),
                   mtgd_pkg::COORD_BITS'($urandom), $urandom);
      end
    end
  endtask

  task automatic test_basic_taps();
    send_event(mtgd_pkg::CMD_ENDED, 0, 0, 0);
    send_event(mtgd_pkg::CMD_BEGAN, -32768, 32767, 10);
    send_event(mtgd_pkg::CMD_MOVED, -32767, 32767, 11);
    send_event(mtgd_pkg::CMD_ENDED, -32767, 32766, 20);
    send_event(mtgd_pkg::CMD_BEGAN, -32768, 32767, 400);
    send_event(mtgd_pkg::CMD_ENDED, -32768, 32767, 520);
    send_event(mtgd_pkg::CMD_BEGAN, -32768, 32767, 900);
    send_event(mtgd_pkg::CMD_ENDED, -32768, 32767, 1021);
    send_event(mtgd_pkg::CMD_BEGAN, 32767, -32768, 1100);
    send_event(mtgd_pkg::CMD_ENDED, -32768, -32768, 1150);
    send_event(mtgd_pkg::CMD_ENDED, 32767, -32768, 1200);
    send_event(mtgd_pkg::CMD_BEGAN, 32767, -32768, 1300);
    send_event(mtgd_pkg::CMD_MOVED, 32765, -32768, 1310);
    send_event(mtgd_pkg::CMD_ENDED, 32765, -32768, 1320);
    send_event(mtgd_pkg::CMD_BEGAN, 5, 5, 1400);
    send_event(mtgd_pkg::CMD_CANCELLED, 5, 5, 1410);
    send_event(mtgd_pkg::CMD_ENDED, 5, 5, 1420);
  endtask

  task automatic test_touch_tolerance_and_wrap();
    set_touchscreen(1'b1);
    write_register(mtgd_pkg::CFG_THRESHOLD, {mtgd_pkg::THR_BITS{1'b1}});
    send_event(mtgd_pkg::CMD_BEGAN, 0, 0, 32'hFFFF_FF00);
    send_event(mtgd_pkg::CMD_ENDED, 40, -40, 32'hFFFF_FFFF);
    send_event(mtgd_pkg::CMD_BEGAN, -40, 40, 32'h0000_0000);
    send_event(mtgd_pkg::CMD_MOVED, 0, 80, 32'h0000_0001);
    send_event(mtgd_pkg::CMD_ENDED, 1, 81, 32'h0000_0002);
    send_event(mtgd_pkg::CMD_ENDED, 0, 80, 32'h0000_1FFE);
    send_event(mtgd_pkg::CMD_BEGAN, 41, 0, 32'h0000_1FFF);
    send_event(mtgd_pkg::CMD_ENDED, 41, 0, 32'h0000_2000);
    write_register(mtgd_pkg::CFG_THRESHOLD, '0);
    send_event(mtgd_pkg::CMD_BEGAN, 41, 0, 32'h0000_2000);
    send_event(mtgd_pkg::CMD_ENDED, 41, 0, 32'h0000_2000);
    send_event(mtgd_pkg::CMD_BEGAN, 41, 0, 32'h0000_2001);
    send_event(mtgd_pkg::CMD_ENDED, 41, 0, 32'h0000_2001);
  endtask

  task automatic test_tap_run();
    logic signed [mtgd_pkg::COORD_BITS-1:0] x, y;
    logic [mtgd_pkg::TIME_BITS-1:0]         stamp;
    int                                     n;
    set_touchscreen(1'b0);
    write_register(mtgd_pkg::CFG_THRESHOLD, mtgd_pkg::THR_BITS'(100));
    x     = mtgd_pkg::COORD_BITS'($urandom);
    y     = mtgd_pkg::COORD_BITS'($urandom);
    stamp = $urandom;
    for (n = 0; n < RUN_TAPS; n++) begin
      send_event(mtgd_pkg::CMD_BEGAN, x, y, stamp);
      send_event(mtgd_pkg::CMD_ENDED, x, y, stamp + 32'd1);
      stamp = stamp + ((n % 13 == 12) ? 32'd150 : 32'd2);
    end
    send_event(mtgd_pkg::CMD_CANCELLED, x, y, stamp);
  endtask

  task automatic test_random_traffic();
    write_register(mtgd_pkg::CFG_THRESHOLD, mtgd_pkg::THR_BITS'(5000));
    random_gestures(PHASE_EVENTS, 1'b0);
    set_touchscreen(1'b1);
    write_register(mtgd_pkg::CFG_THRESHOLD, mtgd_pkg::THR_BITS'(100));
    random_gestures(PHASE_EVENTS, 1'b1);
    write_register(mtgd_pkg::CFG_THRESHOLD, mtgd_pkg::THR_RESET);
    steady = 1'b1;
    random_gestures(PHASE_EVENTS, 1'b0);
    steady = 1'b0;
    set_touchscreen(1'b0);
    write_register(mtgd_pkg::CFG_THRESHOLD, '0);
    random_gestures(PHASE_EVENTS, 1'b0);
    set_touchscreen(1'b1);
    write_register(mtgd_pkg::CFG_THRESHOLD, {mtgd_pkg::THR_BITS{1'b1}});
    random_gestures(PHASE_EVENTS, 1'b0);
  endtask

  initial begin
    forget_gesture();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_taps();
    test_touch_tolerance_and_wrap();
    test_tap_run();
    test_random_traffic();
    settle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
